[hw/rtl/itrd_pkg.sv]
// Shared widths, character codes and the digit-to-ASCII mapping for the radix converter.
`timescale 1ns / 1ps

package itrd_pkg;

  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;
  localparam int DIGIT_W = 6;

  localparam logic [RADIX_W-1:0] MIN_RADIX  = 6'd2;
  localparam logic [CHAR_W-1:0]  MINUS_CODE = 7'd45;
  localparam logic [CHAR_W-1:0]  ZERO_CODE  = 7'd48;
  localparam logic [CHAR_W-1:0]  ALPHA_BASE = 7'd55;
  localparam logic [CHAR_W-1:0]  ERROR_CODE = 7'd0;

  // Digits 0 to 9 map to '0'..'9', digits 10 to 35 map to 'A'..'Z'.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] base;
    base = (d < 6'd10) ? ZERO_CODE : ALPHA_BASE;
    return base + {1'b0, d};
  endfunction

endpackage

[hw/rtl/itrd_if.sv]
// Valid/ready channel interfaces for the converter's input values and output characters.
`timescale 1ns / 1ps

interface itrd_in_if import itrd_pkg::*; #(
  parameter int VALUE_BITS = 32
) ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [RADIX_W-1:0]    radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

interface itrd_out_if import itrd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;
  logic              error;

  modport source (output valid, output char_code, output last, output error, input ready);
  modport sink   (input valid, input char_code, input last, input error, output ready);
endinterface

[hw/rtl/integer_to_radix_digits_top.sv]
// Top level: converts a signed integer into its ASCII digits in a radix from 2 to MAX_RADIX.
`timescale 1ns / 1ps

//  Channel   Direction  Payload                     Transfer
//  in_chan   sink       value, radix                valid && ready
//  out_chan  source     char_code, last, error      valid && ready
//
//  Each digit comes from the bit-serial restoring divider, which produces one
//  quotient bit per cycle and stores the remainder; once the quotient is zero,
//  each character is emitted through a registered digit store read (S_RD) and
//  an output load (S_LD), most significant digit first, after a minus sign if
//  the value is negative; a bad radix or a zero goes out as a single character.
//  Reset (rst_n low, synchronous) returns the sequencer to idle and empties the
//  output register. A stalled output holds the sequencer in S_PUT and S_LD only; a new
//  value is taken while the final character of the previous one still waits in the output.
module integer_to_radix_digits_top import itrd_pkg::*; #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_RADIX  = 36
) (
  input  logic          clk,
  input  logic          rst_n,
  itrd_in_if.sink       in_chan,
  itrd_out_if.source    out_chan
);

  // Address width of the digit store and width of the digit count, which can
  // reach VALUE_BITS itself for radix 2 and the most negative value.
  localparam int AW = $clog2(VALUE_BITS);
  localparam int CW = $clog2(VALUE_BITS + 1);
  localparam logic [RADIX_W-1:0] MAX_RADIX_C = RADIX_W'(MAX_RADIX);
  localparam logic [AW-1:0]      LAST_BIT    = AW'(VALUE_BITS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_PUT  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_LD   = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [RADIX_W-1:0]    radix_r, radix_nxt;
  logic [AW-1:0]         bit_cnt_r, bit_cnt_nxt;
  logic [CW-1:0]         dcount_r, dcount_nxt;
  logic                  neg_r, neg_nxt;

  // Pending single character: error marker, lone zero or minus sign.
  logic [CHAR_W-1:0]     put_char_r, put_char_nxt;
  logic                  put_last_r, put_last_nxt;
  logic                  put_err_r, put_err_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_err_r, out_err_nxt;

  // Digit store: remainders, least significant first.
  logic [DIGIT_W-1:0]    digit_mem [VALUE_BITS];
  logic [DIGIT_W-1:0]    rd_data_r;
  logic                  mem_we;
  logic [CW-1:0]         dcount_dec;
  logic [AW-1:0]         rd_addr;

  logic                  in_xfer;
  logic                  slot_free;
  logic                  radix_bad;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] in_mag;

  // One restoring division step: bring in the next magnitude bit.
  logic [DIGIT_W:0]      trial;
  logic                  q_bit;
  logic [DIGIT_W:0]      trial_sub;
  logic [DIGIT_W-1:0]    step_rem;
  logic [VALUE_BITS-1:0] step_mag;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign slot_free     = !out_valid_r || out_chan.ready;

  assign radix_bad = (in_chan.radix < MIN_RADIX) || (in_chan.radix > MAX_RADIX_C);
  assign in_neg    = in_chan.value[VALUE_BITS-1];
  // The negation wraps the most negative value onto its own unsigned magnitude.
  assign in_mag    = in_neg ? (~in_chan.value + 1'b1) : in_chan.value;

  assign trial     = {rem_r, mag_r[VALUE_BITS-1]};
  assign q_bit     = (trial >= {1'b0, radix_r});
  assign trial_sub = trial - {1'b0, radix_r};
  assign step_rem  = q_bit ? trial_sub[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
  assign step_mag  = {mag_r[VALUE_BITS-2:0], q_bit};

  assign dcount_dec = dcount_r - 1'b1;
  assign rd_addr    = dcount_dec[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    rem_nxt       = rem_r;
    radix_nxt     = radix_r;
    bit_cnt_nxt   = bit_cnt_r;
    dcount_nxt    = dcount_r;
    neg_nxt       = neg_r;
    put_char_nxt  = put_char_r;
    put_last_nxt  = put_last_r;
    put_err_nxt   = put_err_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    mem_we        = 1'b0;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          radix_nxt   = in_chan.radix;
          mag_nxt     = in_mag;
          neg_nxt     = in_neg;
          rem_nxt     = '0;
          bit_cnt_nxt = LAST_BIT;
          dcount_nxt  = '0;
          if (radix_bad) begin
            put_char_nxt = ERROR_CODE;
            put_last_nxt = 1'b1;
            put_err_nxt  = 1'b1;
            state_nxt    = S_PUT;
          end else if (in_mag == '0) begin
            put_char_nxt = ZERO_CODE;
            put_last_nxt = 1'b1;
            put_err_nxt  = 1'b0;
            state_nxt    = S_PUT;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        mag_nxt     = step_mag;
        rem_nxt     = step_rem;
        bit_cnt_nxt = bit_cnt_r - 1'b1;
        if (bit_cnt_r == '0) begin
          // A digit is complete: store the remainder and restart on the quotient.
          mem_we      = 1'b1;
          dcount_nxt  = dcount_r + 1'b1;
          rem_nxt     = '0;
          bit_cnt_nxt = LAST_BIT;
          if (step_mag == '0) begin
            if (neg_r) begin
              put_char_nxt = MINUS_CODE;
              put_last_nxt = 1'b0;
              put_err_nxt  = 1'b0;
              state_nxt    = S_PUT;
            end else begin
              state_nxt = S_RD;
            end
          end
        end
      end
      S_PUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = put_char_r;
          out_last_nxt  = put_last_r;
          out_err_nxt   = put_err_r;
          state_nxt     = put_last_r ? S_IDLE : S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_LD;
      end
      S_LD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(rd_data_r);
          out_last_nxt  = (dcount_r == CW'(1));
          out_err_nxt   = 1'b0;
          dcount_nxt    = dcount_dec;
          state_nxt     = (dcount_r == CW'(1)) ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bit_cnt_r   <= '0;
      dcount_r    <= '0;
      neg_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      dcount_r    <= dcount_nxt;
      neg_r       <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    rem_r      <= rem_nxt;
    radix_r    <= radix_nxt;
    put_char_r <= put_char_nxt;
    put_last_r <= put_last_nxt;
    put_err_r  <= put_err_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  // Digit store, written during division and read one digit per character.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[dcount_r[AW-1:0]] <= step_rem;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= digit_mem[rd_addr];
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.char_code = out_char_r;
  assign out_chan.last      = out_last_r;
  assign out_chan.error     = out_err_r;

endmodule
